@@ rtl/pli_pkg.sv @@
// ----------------------------------------------------------------------------
// pli_pkg
// Shared types and constants for the piecewise linear interpolator.
// ----------------------------------------------------------------------------
package pli_pkg;

   localparam int TableDepth = 256;
   localparam int AddrWidth  = $clog2(TableDepth);
   localparam int CountWidth = AddrWidth + 1;
   localparam int EntryWidth = 88;

   localparam logic [1:0] REQ_CLEAR    = 2'd0;
   localparam logic [1:0] REQ_APPEND   = 2'd1;
   localparam logic [1:0] REQ_QUERY    = 2'd2;
   localparam logic [1:0] REQ_RESERVED = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]         req_type;
      logic signed [31:0] key_x;
      logic signed [31:0] value_y;
      logic [7:0]         point_red;
      logic [7:0]         point_green;
      logic [7:0]         point_blue;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic [7:0]         result_red;
      logic [7:0]         result_green;
      logic [7:0]         result_blue;
      logic [1:0]         status;
      logic [8:0]         point_count;
   } rsp_word_type;

endpackage

@@ rtl/pli_ram.sv @@
// ----------------------------------------------------------------------------
// pli_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pli_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/pli_divider.sv @@
// ----------------------------------------------------------------------------
// pli_divider
// Restoring divider: floor((dx << 16) / span), one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pli_divider import pli_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dx,
   input  logic [31:0] span,
   output logic        done,
   output logic [15:0] portion
);
   logic [47:0] num_ff;
   logic [31:0] rem_ff;
   logic [31:0] span_ff;
   logic [5:0]  cnt_ff;
   logic        run_ff;
   logic [32:0] trial;

   // remainder stays below span, so 32 bits hold it
   always_comb begin
      trial = {rem_ff, num_ff[47]} - {1'b0, span_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done   <= 1'b0;
      end else begin
         done <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            num_ff  <= {dx, 16'd0};
            rem_ff  <= '0;
            span_ff <= span;
            cnt_ff  <= 6'd0;
         end else if (run_ff) begin
            if (!trial[32]) begin
               rem_ff <= trial[31:0];
               num_ff <= {num_ff[46:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[30:0], num_ff[47]};
               num_ff <= {num_ff[46:0], 1'b0};
            end
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'd47) begin
               run_ff <= 1'b0;
               done   <= 1'b1;
            end
         end
      end
   end

   assign portion = num_ff[15:0];
endmodule

@@ rtl/piecewise_linear_interpolator.sv @@
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// Breakpoint table with linear scan and fixed point interpolation.
// ----------------------------------------------------------------------------
// sequence: clear/append go straight to the response; a query scans the keys
//   with one memory read per key, bounded by the table depth, then when
//   interpolating reads the left neighbour and runs the 48-step serial divider
// one word at a time: busy is high from accept until the response strobe
// reset clears count, default value and control; table contents undefined
// the receiver cannot stall, the response strobe lasts one cycle
module piecewise_linear_interpolator import pli_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_word_type req_word,
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data,
   output logic         rsp_valid,
   output rsp_word_type rsp_word
);
   typedef enum logic [3:0] {
      S_IDLE, S_READ, S_CHECK, S_PREV, S_PREVW, S_DIV, S_DIVW, S_LERP, S_DONE
   } state_type;

   state_type            state_ff;
   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] idx_ff;
   logic [31:0]          dflt_ff;
   logic [31:0]          qx_ff;
   logic [EntryWidth-1:0] right_ff;
   logic [15:0]          portion_ff;
   rsp_word_type         rsp_ff;

   logic                 wr_en;
   logic [AddrWidth-1:0] rd_addr;
   logic [EntryWidth-1:0] rd_data;
   logic                 div_start;
   logic                 div_done;
   logic [15:0]          div_portion;

   // entry = {key, value, r, g, b}
   assign wr_en = start && !busy && req_word.req_type == REQ_APPEND
                  && count_ff < CountWidth'(TableDepth);

   pli_ram #(.Width(EntryWidth), .Depth(TableDepth)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AddrWidth-1:0]),
      .wr_data ({req_word.key_x, req_word.value_y, req_word.point_red,
                 req_word.point_green, req_word.point_blue}),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   logic [31:0] bx, bk, bkl;
   assign bx  = qx_ff ^ 32'h8000_0000;
   assign bk  = rd_data[87:56] ^ 32'h8000_0000;
   assign bkl = rd_data[87:56] ^ 32'h8000_0000;
   logic [31:0] bkr;
   assign bkr = right_ff[87:56] ^ 32'h8000_0000;

   assign div_start = state_ff == S_DIV;

   pli_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dx      (bx - bkl),
      .span    (bkr - bkl),
      .done    (div_done),
      .portion (div_portion)
   );

   logic [55:0] left_ff;

   function automatic logic [31:0] lerp(input logic [31:0] l, input logic [31:0] r,
                                        input logic [15:0] p);
      logic [47:0] prod;
      begin
         if (r >= l) begin
            prod = {16'd0, r - l} * {32'd0, p};
            lerp = l + prod[47:16];
         end else begin
            prod = {16'd0, l - r} * {32'd0, p} + 48'hFFFF;
            lerp = l - prod[47:16];
         end
      end
   endfunction

   function automatic rsp_word_type pack_rsp(input logic [31:0] v, input logic [23:0] c,
                                             input logic [1:0] s, input logic [8:0] n);
      rsp_word_type o;
      begin
         o.result_value = v;
         {o.result_red, o.result_green, o.result_blue} = c;
         o.status = s;
         o.point_count = n;
         pack_rsp = o;
      end
   endfunction

   logic [31:0] lv, lr, lg, lb;
   always_comb begin
      lv = lerp(left_ff[55:24] ^ 32'h8000_0000, right_ff[55:24] ^ 32'h8000_0000,
                portion_ff) ^ 32'h8000_0000;
      lr = lerp({24'd0, left_ff[23:16]}, {24'd0, right_ff[23:16]}, portion_ff);
      lg = lerp({24'd0, left_ff[15:8]},  {24'd0, right_ff[15:8]},  portion_ff);
      lb = lerp({24'd0, left_ff[7:0]},   {24'd0, right_ff[7:0]},   portion_ff);
   end

   // left neighbour stays addressed until the division is done
   always_comb begin
      rd_addr = idx_ff[AddrWidth-1:0];
      if (state_ff inside {S_PREV, S_PREVW, S_DIV, S_DIVW}) begin
         rd_addr = AddrWidth'(idx_ff - 1'b1);
      end
   end

   assign busy = state_ff != S_IDLE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         dflt_ff   <= '0;
         rsp_valid <= 1'b0;
      end else begin
         rsp_valid <= 1'b0;
         if (csr_wr_en) begin
            dflt_ff <= csr_wr_data;
         end
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  qx_ff  <= req_word.key_x;
                  idx_ff <= '0;
                  case (req_word.req_type)
                     REQ_CLEAR: begin
                        count_ff <= '0;
                        rsp_ff   <= pack_rsp('0, '0, STATUS_OK, '0);
                        state_ff <= S_DONE;
                     end
                     REQ_APPEND: begin
                        if (wr_en) begin
                           count_ff <= count_ff + 1'b1;
                           rsp_ff   <= pack_rsp('0, '0, STATUS_OK, 9'(count_ff + 1'b1));
                        end else begin
                           rsp_ff <= pack_rsp('0, '0, STATUS_FULL, 9'(count_ff));
                        end
                        state_ff <= S_DONE;
                     end
                     REQ_QUERY: begin
                        if (count_ff == '0) begin
                           rsp_ff   <= pack_rsp(dflt_ff, 24'h0000FF, STATUS_EMPTY,
                                                9'(count_ff));
                           state_ff <= S_DONE;
                        end else begin
                           rsp_ff   <= pack_rsp('0, '0, STATUS_OK, 9'(count_ff));
                           state_ff <= S_READ;
                        end
                     end
                     default: begin
                        rsp_ff   <= pack_rsp('0, '0, STATUS_OK, 9'(count_ff));
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_READ: state_ff <= S_CHECK;
            S_CHECK: begin
               right_ff <= rd_data;
               if (bk < bx && idx_ff + 1'b1 < count_ff) begin
                  idx_ff   <= idx_ff + 1'b1;
                  state_ff <= S_READ;
               end else if (bk < bx || bk == bx || idx_ff == '0) begin
                  // clamp or exact hit: this entry is the answer
                  rsp_ff   <= pack_rsp(rd_data[55:24], rd_data[23:0], STATUS_OK,
                                       rsp_ff.point_count);
                  state_ff <= S_DONE;
               end else begin
                  state_ff <= S_PREV;
               end
            end
            S_PREV:  state_ff <= S_PREVW;
            S_PREVW: state_ff <= S_DIV;
            S_DIV: begin
               left_ff  <= rd_data[55:0];
               state_ff <= S_DIVW;
            end
            S_DIVW: begin
               if (div_done) begin
                  portion_ff <= div_portion;
                  state_ff   <= S_LERP;
               end
            end
            S_LERP: begin
               rsp_ff   <= pack_rsp(lv, {lr[7:0], lg[7:0], lb[7:0]}, STATUS_OK,
                                    rsp_ff.point_count);
               state_ff <= S_DONE;
            end
            S_DONE: begin
               rsp_valid <= 1'b1;
               state_ff  <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_word = rsp_ff;

   // the table read address must hold still while the division runs
   a_left_stable: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIVW |-> $stable(rd_addr))
      else $error("table read address moved during division");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(TableDepth))
      else $error("point count beyond table depth");

   a_rsp_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted word did not raise busy");
endmodule
